[sv/tnsc_pkg.sv]
// Shared types and constants for the triangle normal / stress colour block.
// Used by the controller, the datapath and the top level.
`default_nettype none
package tnsc_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DIV_QBITS = 15;

  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_CENTER_Z    = 3'd2;
  localparam logic [2:0] REG_SCALE       = 3'd3;
  localparam logic [2:0] REG_DEFORM_GAIN = 3'd4;
  localparam logic [2:0] REG_STRESS_LOW  = 3'd5;
  localparam logic [2:0] REG_STRESS_HIGH = 3'd6;

  localparam logic [15:0] NORM_ONE   = 16'd16384;
  localparam logic [12:0] COLOR_ONE  = 13'd4096;
  localparam logic [12:0] STEEL_RED  = 13'd2458;
  localparam logic [12:0] STEEL_GRN  = 13'd2867;
  localparam logic [12:0] STEEL_BLU  = 13'd3277;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_XF_DG,
    OP_XF_SUM,
    OP_XF_HI,
    OP_XF_LO,
    OP_XF_STORE,
    OP_COL_START,
    OP_COL_STORE,
    OP_HOLD,
    OP_EDGE,
    OP_CROSS,
    OP_MAG,
    OP_SHIFT,
    OP_SQ,
    OP_SQRT_START,
    OP_NDIV_START,
    OP_NDIV_STORE,
    OP_NORM_DEF,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic cross_zero;
    logic mag_big;
  } stat_t;

endpackage
`default_nettype wire

[sv/triangle_normal_stress_colorizer_core.sv]
// Flat-shaded triangle builder with rainbow stress colouring.
// Input channel (in_*): one mesh vertex per word: position, displacement,
// stress and a has-stress flag. Each vertex is centred, deformed by the
// gain, scaled and saturated (Q16.16), and gets a rainbow colour (Q1.12)
// or steel-blue when it carries no stress.
// Output channel (out_*): after every third vertex, three words leave in
// vertex order, all with the same unit face normal (Q1.14); the third has
// out_last set. The first and second vertex of a triangle give no output.
// Configuration channel (cfg_*): register index and data, always ready;
// write only while the block is idle.
// Sequence: one vertex at a time. Transform runs on the shared multiplier
// and colour on the 15-step divider before in_ready returns. The closing
// vertex then adds edges and cross product, magnitudes and narrowing (one
// bit at a time), squares, the 32-step root and three divisions before its
// first output word is valid; a degenerate face goes from the magnitudes
// straight to the default normal. Each later word is loaded in an emit
// state after the one before is taken. Output words are held until taken;
// while out_ready is low the block waits and accepts no vertex. Reset
// clears the vertex count and loads the register defaults; no clearing
// pass is needed.
`default_nettype none
module triangle_normal_stress_colorizer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_disp_x,
  input  wire logic [31:0] in_disp_y,
  input  wire logic [31:0] in_disp_z,
  input  wire logic [30:0] in_stress,
  input  wire logic        in_has_stress,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_z,
  output logic [15:0]      out_norm_x,
  output logic [15:0]      out_norm_y,
  output logic [15:0]      out_norm_z,
  output logic [12:0]      out_red,
  output logic [12:0]      out_green,
  output logic [12:0]      out_blue,
  output logic             out_last
);
  import tnsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tnsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tnsc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_disp_x     (in_disp_x),
    .in_disp_y     (in_disp_y),
    .in_disp_z     (in_disp_z),
    .in_stress     (in_stress),
    .in_has_stress (in_has_stress),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_norm_x    (out_norm_x),
    .out_norm_y    (out_norm_y),
    .out_norm_z    (out_norm_z),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last      (out_last)
  );
endmodule
`default_nettype wire

[sv/tnsc_div.sv]
// Restoring divider, one quotient bit per cycle, quotient below 2^DIV_QBITS.
// Depends on tnsc_pkg.
`default_nettype none
module tnsc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [46:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [14:0]      quot
);
  import tnsc_pkg::*;

  logic [46:0] rem_r;
  logic [46:0] dsh_r;
  logic [14:0] q_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic        ge;

  assign ge = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'(DIV_QBITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= {1'b0, divisor, 14'b0};
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dsh_r;
      q_r   <= {q_r[13:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

[sv/tnsc_sqrt.sv]
// Integer square root of a 64-bit word, one result bit per cycle.
// Depends on tnsc_pkg only for house consistency of the import.
`default_nettype none
module tnsc_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);
  import tnsc_pkg::*;

  logic [63:0] v_r;
  logic [63:0] r_r;
  logic [63:0] bit_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];
endmodule
`default_nettype wire

[sv/tnsc_ctrl.sv]
// Sequencer: walks one vertex through transform and colour, and closes a
// triangle every third vertex. Depends on tnsc_pkg.
`default_nettype none
module tnsc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire tnsc_pkg::stat_t stat,
  output tnsc_pkg::cmd_t      cmd
);
  import tnsc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_XF_DG, S_XF_SUM, S_XF_HI, S_XF_LO, S_XF_ST,
    S_COL, S_COL_W, S_COL_ST, S_HOLD,
    S_EDGE, S_CROSS, S_MAG, S_SHIFT, S_SQ, S_SQRT, S_SQRT_W,
    S_NDIV, S_NDIV_W, S_NDIV_ST, S_NDEF, S_EMIT, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    ov_nxt    = ov_r;
    cmd.op    = OP_NOP;
    cmd.idx   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          idx_nxt   = 3'd0;
          state_nxt = S_XF_DG;
        end
      end
      S_XF_DG: begin
        cmd.op    = OP_XF_DG;
        state_nxt = S_XF_SUM;
      end
      S_XF_SUM: begin
        cmd.op    = OP_XF_SUM;
        state_nxt = S_XF_HI;
      end
      S_XF_HI: begin
        cmd.op    = OP_XF_HI;
        state_nxt = S_XF_LO;
      end
      S_XF_LO: begin
        cmd.op    = OP_XF_LO;
        state_nxt = S_XF_ST;
      end
      S_XF_ST: begin
        cmd.op = OP_XF_STORE;
        if (idx_r == 3'd2) begin
          idx_nxt   = 3'd0;
          state_nxt = S_COL;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_XF_DG;
        end
      end
      S_COL: begin
        cmd.op    = OP_COL_START;
        state_nxt = S_COL_W;
      end
      S_COL_W: begin
        if (stat.div_done) state_nxt = S_COL_ST;
      end
      S_COL_ST: begin
        cmd.op    = OP_COL_STORE;
        state_nxt = (phase_r == 2'd2) ? S_EDGE : S_HOLD;
      end
      S_HOLD: begin
        cmd.op    = OP_HOLD;
        cmd.idx   = {1'b0, phase_r};
        phase_nxt = phase_r + 2'd1;
        state_nxt = S_IDLE;
      end
      S_EDGE: begin
        cmd.op    = OP_EDGE;
        idx_nxt   = 3'd0;
        state_nxt = S_CROSS;
      end
      S_CROSS: begin
        cmd.op = OP_CROSS;
        if (idx_r == 3'd6) begin
          state_nxt = S_MAG;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        // narrow the magnitudes one bit a cycle until all fit in 31 bits
        if (stat.cross_zero) begin
          state_nxt = S_NDEF;
        end else if (stat.mag_big) begin
          cmd.op = OP_SHIFT;
        end else begin
          idx_nxt   = 3'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (idx_r == 3'd3) begin
          state_nxt = S_SQRT;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      S_SQRT: begin
        cmd.op    = OP_SQRT_START;
        state_nxt = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (stat.sqrt_done) begin
          idx_nxt   = 3'd0;
          state_nxt = S_NDIV;
        end
      end
      S_NDIV: begin
        cmd.op    = OP_NDIV_START;
        state_nxt = S_NDIV_W;
      end
      S_NDIV_W: begin
        if (stat.div_done) state_nxt = S_NDIV_ST;
      end
      S_NDIV_ST: begin
        cmd.op = OP_NDIV_STORE;
        if (idx_r == 3'd2) begin
          idx_nxt   = 3'd0;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_NDIV;
        end
      end
      S_NDEF: begin
        cmd.op    = OP_NORM_DEF;
        idx_nxt   = 3'd0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.op    = OP_EMIT;
        ov_nxt    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          ov_nxt = 1'b0;
          if (idx_r == 3'd2) begin
            phase_nxt = 2'd0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = S_EMIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      phase_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
endmodule
`default_nettype wire

[sv/tnsc_dp.sv]
// Datapath: configuration registers, shared multiplier, held vertices,
// edge/cross/normal registers and the divider and root units.
// Depends on tnsc_pkg, tnsc_div and tnsc_sqrt.
`default_nettype none
module tnsc_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tnsc_pkg::cmd_t cmd,
  output tnsc_pkg::stat_t     stat,
  input  wire logic           cfg_valid,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [31:0]    cfg_data,
  input  wire logic [31:0]    in_pos_x,
  input  wire logic [31:0]    in_pos_y,
  input  wire logic [31:0]    in_pos_z,
  input  wire logic [31:0]    in_disp_x,
  input  wire logic [31:0]    in_disp_y,
  input  wire logic [31:0]    in_disp_z,
  input  wire logic [30:0]    in_stress,
  input  wire logic           in_has_stress,
  output logic [31:0]         out_x,
  output logic [31:0]         out_y,
  output logic [31:0]         out_z,
  output logic [15:0]         out_norm_x,
  output logic [15:0]         out_norm_y,
  output logic [15:0]         out_norm_z,
  output logic [12:0]         out_red,
  output logic [12:0]         out_green,
  output logic [12:0]         out_blue,
  output logic                out_last
);
  import tnsc_pkg::*;

  logic [31:0] cx_r, cy_r, cz_r, gain_r;
  logic [30:0] scale_r, slo_r, shi_r;

  logic [31:0] pos_r [3];
  logic [31:0] disp_r [3];
  logic [30:0] str_r;
  logic        has_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic        t_neg_r;
  logic [48:0] m_r;
  logic [47:0] hip_r;

  logic [31:0] cur_p_r [3];
  logic [12:0] cur_c_r [3];
  logic [31:0] held_p_r [2][3];
  logic [12:0] held_c_r [2][3];
  logic        col_neg_r;

  logic [31:0] e_r [6];
  logic signed [65:0] c_r [3];
  logic [2:0]  csgn_r;
  logic [63:0] mag_r [3];
  logic [63:0] sum_r;
  logic [15:0] nrm_r [3];

  logic [1:0]  ax;
  logic [31:0] cen;
  logic [2:0]  ea, eb;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      cz_r    <= '0;
      scale_r <= 31'd65536;
      gain_r  <= 32'd65536;
      slo_r   <= '0;
      shi_r   <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:    cx_r    <= cfg_data;
        REG_CENTER_Y:    cy_r    <= cfg_data;
        REG_CENTER_Z:    cz_r    <= cfg_data;
        REG_SCALE:       scale_r <= cfg_data[30:0];
        REG_DEFORM_GAIN: gain_r  <= cfg_data;
        REG_STRESS_LOW:  slo_r   <= cfg_data[30:0];
        REG_STRESS_HIGH: shi_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign ax = cmd.idx[1:0];

  always_comb begin
    case (ax)
      2'd0:    cen = cx_r;
      2'd1:    cen = cy_r;
      default: cen = cz_r;
    endcase
  end

  // cross product operand pairs: (e1,e5) (e2,e4) (e2,e3) (e0,e5) (e0,e4) (e1,e3)
  always_comb begin
    case (cmd.idx)
      3'd0:    begin ea = 3'd1; eb = 3'd5; end
      3'd1:    begin ea = 3'd2; eb = 3'd4; end
      3'd2:    begin ea = 3'd2; eb = 3'd3; end
      3'd3:    begin ea = 3'd0; eb = 3'd5; end
      3'd4:    begin ea = 3'd0; eb = 3'd4; end
      default: begin ea = 3'd1; eb = 3'd3; end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_XF_DG: begin
        mul_a = $signed({disp_r[ax][31], disp_r[ax]});
        mul_b = $signed({gain_r[31], gain_r});
      end
      OP_XF_HI: begin
        mul_a = $signed({16'b0, m_r[48:32]});
        mul_b = $signed({2'b0, scale_r});
      end
      OP_XF_LO: begin
        mul_a = $signed({1'b0, m_r[31:0]});
        mul_b = $signed({2'b0, scale_r});
      end
      OP_CROSS: begin
        if (cmd.idx != 3'd6) begin
          mul_a = $signed({e_r[ea][31], e_r[ea]});
          mul_b = $signed({e_r[eb][31], e_r[eb]});
        end
      end
      OP_SQ: begin
        if (cmd.idx != 3'd3) begin
          mul_a = $signed({2'b0, mag_r[ax][30:0]});
          mul_b = $signed({2'b0, mag_r[ax][30:0]});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // position transform
  logic [32:0]        diff;
  logic signed [65:0] tsum, tmag;
  logic [46:0]        lo_sh;
  logic [47:0]        rsum, lim, rsel;
  logic [31:0]        xf_res;

  always_comb begin
    diff   = {pos_r[ax][31], pos_r[ax]} - {cen[31], cen};
    tsum   = $signed({{17{diff[32]}}, diff, 16'b0}) + prod_r;
    tmag   = tsum[65] ? -tsum : tsum;
    lo_sh  = prod_r[62:16];
    rsum   = {16'b0, hip_r[15:0], 16'b0} + {1'b0, lo_sh};
    lim    = t_neg_r ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
    if (|hip_r[47:16]) rsel = lim;
    else if (rsum > lim) rsel = lim;
    else rsel = rsum;
    xf_res = t_neg_r ? (32'd0 - rsel[31:0]) : rsel[31:0];
  end

  // colour dividend
  logic [30:0] vcl, span, vd;
  logic [32:0] nm;
  logic [31:0] nmag;
  logic [46:0] col_dvd;
  logic        range_ok;

  always_comb begin
    range_ok = shi_r > slo_r;
    if (str_r < slo_r) vcl = slo_r;
    else if (str_r > shi_r) vcl = shi_r;
    else vcl = str_r;
    span    = shi_r - slo_r;
    vd      = vcl - slo_r;
    nm      = {1'b0, vd, 1'b0} - {2'b0, span};
    nmag    = nm[32] ? 32'(33'd0 - nm) : nm[31:0];
    col_dvd = {3'b0, nmag, 12'b0} + {17'b0, span[30:1]};
  end

  // edges
  logic [32:0] ed [6];
  logic [32:0] edm [6];
  logic        ebig;

  always_comb begin
    ebig = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ed[i]     = {held_p_r[1][i][31], held_p_r[1][i]} - {held_p_r[0][i][31], held_p_r[0][i]};
      ed[i + 3] = {cur_p_r[i][31], cur_p_r[i]} - {held_p_r[0][i][31], held_p_r[0][i]};
    end
    for (int i = 0; i < 6; i++) begin
      edm[i] = ed[i][32] ? (33'd0 - ed[i]) : ed[i];
      if (|edm[i][32:31]) ebig = 1'b1;
    end
  end

  // shared divider and root
  logic        div_start, div_done, sqrt_done;
  logic [46:0] div_dvd;
  logic [31:0] div_dvs, root;
  logic [14:0] quot;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = col_dvd;
    div_dvs   = {1'b0, span};
    if (cmd.op == OP_COL_START) begin
      div_start = 1'b1;
    end else if (cmd.op == OP_NDIV_START) begin
      div_start = 1'b1;
      div_dvd   = {2'b0, mag_r[ax][30:0], 14'b0} + {16'b0, root[31:1]};
      div_dvs   = root;
    end
  end

  tnsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (quot)
  );

  tnsc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_SQRT_START),
    .radicand (sum_r),
    .done     (sqrt_done),
    .root     (root)
  );

  logic [2:0] acc_k;
  assign acc_k = cmd.idx - 3'd1;

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        pos_r[0]  <= in_pos_x;
        pos_r[1]  <= in_pos_y;
        pos_r[2]  <= in_pos_z;
        disp_r[0] <= in_disp_x;
        disp_r[1] <= in_disp_y;
        disp_r[2] <= in_disp_z;
        str_r     <= in_stress;
        has_r     <= in_has_stress;
      end
      OP_XF_SUM: begin
        t_neg_r <= tsum[65];
        m_r     <= tmag[64:16];
      end
      OP_XF_LO: hip_r <= prod_r[47:0];
      OP_XF_STORE: cur_p_r[ax] <= xf_res;
      OP_COL_START: col_neg_r <= nm[32];
      OP_COL_STORE: begin
        if (!has_r) begin
          cur_c_r[0] <= STEEL_RED;
          cur_c_r[1] <= STEEL_GRN;
          cur_c_r[2] <= STEEL_BLU;
        end else if (!range_ok) begin
          cur_c_r[0] <= '0;
          cur_c_r[1] <= COLOR_ONE;
          cur_c_r[2] <= '0;
        end else begin
          cur_c_r[0] <= col_neg_r ? 13'd0 : quot[12:0];
          cur_c_r[1] <= COLOR_ONE - quot[12:0];
          cur_c_r[2] <= col_neg_r ? quot[12:0] : 13'd0;
        end
      end
      OP_HOLD: begin
        held_p_r[cmd.idx[0]] <= cur_p_r;
        held_c_r[cmd.idx[0]] <= cur_c_r;
      end
      OP_EDGE: begin
        for (int i = 0; i < 6; i++) begin
          if (ebig) begin
            // halve toward zero
            e_r[i] <= ed[i][32] ? (32'd0 - {1'b0, edm[i][31:1]}) : {1'b0, edm[i][31:1]};
          end else begin
            e_r[i] <= ed[i][31:0];
          end
        end
      end
      OP_CROSS: begin
        if (cmd.idx != 3'd0) begin
          if (!acc_k[0]) c_r[acc_k[2:1]] <= prod_r;
          else c_r[acc_k[2:1]] <= c_r[acc_k[2:1]] - prod_r;
        end
      end
      OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          csgn_r[i] <= c_r[i][65];
          mag_r[i]  <= c_r[i][65] ? 64'(66'sd0 - c_r[i]) : c_r[i][63:0];
        end
      end
      OP_SHIFT: begin
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
      end
      OP_SQ: begin
        if (cmd.idx == 3'd1) sum_r <= prod_r[63:0];
        else if (cmd.idx != 3'd0) sum_r <= sum_r + prod_r[63:0];
      end
      OP_NDIV_STORE: begin
        nrm_r[ax] <= csgn_r[ax] ? (16'd0 - {1'b0, quot}) : {1'b0, quot};
      end
      OP_NORM_DEF: begin
        nrm_r[0] <= '0;
        nrm_r[1] <= NORM_ONE;
        nrm_r[2] <= '0;
      end
      OP_EMIT: begin
        case (ax)
          2'd0: begin
            out_x     <= held_p_r[0][0];
            out_y     <= held_p_r[0][1];
            out_z     <= held_p_r[0][2];
            out_red   <= held_c_r[0][0];
            out_green <= held_c_r[0][1];
            out_blue  <= held_c_r[0][2];
          end
          2'd1: begin
            out_x     <= held_p_r[1][0];
            out_y     <= held_p_r[1][1];
            out_z     <= held_p_r[1][2];
            out_red   <= held_c_r[1][0];
            out_green <= held_c_r[1][1];
            out_blue  <= held_c_r[1][2];
          end
          default: begin
            out_x     <= cur_p_r[0];
            out_y     <= cur_p_r[1];
            out_z     <= cur_p_r[2];
            out_red   <= cur_c_r[0];
            out_green <= cur_c_r[1];
            out_blue  <= cur_c_r[2];
          end
        endcase
        out_norm_x <= nrm_r[0];
        out_norm_y <= nrm_r[1];
        out_norm_z <= nrm_r[2];
        out_last   <= (ax == 2'd2);
      end
      default: ;
    endcase
  end

  assign stat.div_done   = div_done;
  assign stat.sqrt_done  = sqrt_done;
  assign stat.cross_zero = (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
  assign stat.mag_big    = (|mag_r[0][63:31]) || (|mag_r[1][63:31]) || (|mag_r[2][63:31]);
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking bench for triangle_normal_stress_colorizer_core: directed
// table then randomised vertex phases, checked against an in-bench predictor.
// Depends on tnsc_pkg for the register indexes and the colour constants.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tnsc_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [31:0] px, py, pz, dx, dy, dz;
    logic [30:0] st;
    logic        hs;
    bit          typed;
    logic [31:0] ex, ey, ez;
    logic [12:0] er, eg, eb;
    bit          tnorm;
    logic [15:0] enx, eny, enz;
  } vertex_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic [15:0] nx, ny, nz;
    logic [12:0] r, g, b;
    logic        last;
  } vert_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [31:0] in_disp_x = '0, in_disp_y = '0, in_disp_z = '0;
  logic [30:0] in_stress = '0;
  logic in_has_stress = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_x, out_y, out_z;
  logic [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic [12:0] out_red, out_green, out_blue;
  logic out_last;

  always #1 clk = ~clk;

  triangle_normal_stress_colorizer_core dut (.*);

  // predictor copy of the registers and vertex state
  longint          ctr_x = 0, ctr_y = 0, ctr_z = 0, gain = 65536;
  longint unsigned scale = 65536, s_low = 0, s_high = 65536;
  int              vphase = 0;
  vert_word_t      held_vert [2];

  vertex_t    offered_q [$];
  vert_word_t tri_words_q [$];
  int  fails = 0;
  int  words_seen = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint shr_tz(longint v, int k);
    return v < 0 ? -longint'(mag(v) >> k) : longint'(mag(v) >> k);
  endfunction

  function automatic logic [31:0] place_coord(logic [31:0] p, logic [31:0] d, longint c);
    longint t;
    longint unsigned m, hi, lo, lim, r;
    t = (longint'($signed(p)) - c) * 65536 + longint'($signed(d)) * gain;
    m = mag(t) >> 16;
    hi = (m >> 32) * scale;
    lo = (m & 64'hFFFF_FFFF) * scale;
    lim = t < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (hi >= 65536) r = lim;
    else begin
      r = (hi << 16) + (lo >> 16);
      if (r > lim) r = lim;
    end
    return t < 0 ? 32'(-longint'(r)) : 32'(r);
  endfunction

  function automatic void rainbow(logic [30:0] s, logic hs, ref vert_word_t w);
    longint v, span, num, u;
    longint unsigned q;
    u = 0;
    if (!hs) begin
      w.r = STEEL_RED; w.g = STEEL_GRN; w.b = STEEL_BLU;
      return;
    end
    if (s_high > s_low) begin
      v = longint'(s);
      span = longint'(s_high) - longint'(s_low);
      if (v < longint'(s_low)) v = s_low;
      if (v > longint'(s_high)) v = s_high;
      num = (2 * (v - longint'(s_low)) - span) * 4096;
      q = (mag(num) + longint'(span) / 2) / longint'(span);
      u = num < 0 ? -longint'(q) : longint'(q);
    end
    w.r = u > 0 ? 13'(u) : 13'd0;
    w.g = 13'(4096 - (u < 0 ? -u : u));
    w.b = u < 0 ? 13'(-u) : 13'd0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else r >>= 1;
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic void face_normal(vert_word_t a, vert_word_t b, vert_word_t c,
                                      ref vert_word_t n);
    longint e [6];
    longint cr [3];
    longint unsigned m [3];
    longint unsigned mx, sum, len, q;
    int k;
    e[0] = longint'($signed(b.x)) - longint'($signed(a.x));
    e[1] = longint'($signed(b.y)) - longint'($signed(a.y));
    e[2] = longint'($signed(b.z)) - longint'($signed(a.z));
    e[3] = longint'($signed(c.x)) - longint'($signed(a.x));
    e[4] = longint'($signed(c.y)) - longint'($signed(a.y));
    e[5] = longint'($signed(c.z)) - longint'($signed(a.z));
    mx = 0;
    for (int i = 0; i < 6; i++) if (mag(e[i]) > mx) mx = mag(e[i]);
    k = 0;
    while ((mx >> k) >= 64'h8000_0000) k++;
    for (int i = 0; i < 6; i++) e[i] = shr_tz(e[i], k);
    cr[0] = e[1] * e[5] - e[2] * e[4];
    cr[1] = e[2] * e[3] - e[0] * e[5];
    cr[2] = e[0] * e[4] - e[1] * e[3];
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
      n.nx = 0; n.ny = NORM_ONE; n.nz = 0;
      return;
    end
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(cr[i]);
      if (m[i] > mx) mx = m[i];
    end
    k = 0;
    while ((mx >> k) >= 64'h8000_0000) k++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] >>= k;
      sum += m[i] * m[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + len / 2) / len;
      cr[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
    end
    n.nx = 16'(cr[0]); n.ny = 16'(cr[1]); n.nz = 16'(cr[2]);
  endfunction

  // take one accepted vertex; on the third, queue the whole triangle
  function automatic void take_vertex(vertex_t v);
    vert_word_t w, nw;
    w.x = place_coord(v.px, v.dx, ctr_x);
    w.y = place_coord(v.py, v.dy, ctr_y);
    w.z = place_coord(v.pz, v.dz, ctr_z);
    rainbow(v.st, v.hs, w);
    w.nx = 0; w.ny = 0; w.nz = 0; w.last = 1'b0;
    if (v.typed) begin
      w.x = v.ex; w.y = v.ey; w.z = v.ez;
      w.r = v.er; w.g = v.eg; w.b = v.eb;
    end
    if (vphase < 2) begin
      held_vert[vphase] = w;
      vphase++;
      return;
    end
    face_normal(held_vert[0], held_vert[1], w, nw);
    if (v.tnorm) begin
      nw.nx = v.enx; nw.ny = v.eny; nw.nz = v.enz;
    end
    for (int i = 0; i < 3; i++) begin
      vert_word_t o;
      o = i == 2 ? w : held_vert[i];
      o.nx = nw.nx; o.ny = nw.ny; o.nz = nw.nz;
      o.last = i == 2;
      tri_words_q = {tri_words_q, o};
    end
    vphase = 0;
  endfunction

  function automatic void field_check(string nm, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %h, actual %h", $realtime, nm, e, a);
      fails++;
    end
  endfunction

  // monitor: apply writes and vertices to the predictor, check result words
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X:    ctr_x = longint'($signed(cfg_data));
          REG_CENTER_Y:    ctr_y = longint'($signed(cfg_data));
          REG_CENTER_Z:    ctr_z = longint'($signed(cfg_data));
          REG_SCALE:       scale = cfg_data[30:0];
          REG_DEFORM_GAIN: gain = longint'($signed(cfg_data));
          REG_STRESS_LOW:  s_low = cfg_data[30:0];
          REG_STRESS_HIGH: s_high = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_vertex(offered_q.pop_front());
      if (out_valid && out_ready) begin
        words_seen++;
        if (tri_words_q.size() == 0) begin
          $display("%0t unexpected output word x=%h", $realtime, out_x);
          fails++;
        end else begin
          vert_word_t e;
          e = tri_words_q.pop_front();
          field_check("x", e.x, out_x);
          field_check("y", e.y, out_y);
          field_check("z", e.z, out_z);
          field_check("norm_x", e.nx, out_norm_x);
          field_check("norm_y", e.ny, out_norm_y);
          field_check("norm_z", e.nz, out_norm_z);
          field_check("red", e.r, out_red);
          field_check("green", e.g, out_green);
          field_check("blue", e.b, out_blue);
          field_check("last", e.last, out_last);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off to back the block up
  initial begin
    bit held_long;
    held_long = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_long && words_seen >= 20) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (799) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else out_ready <= 1'b1;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // entered and left at a falling edge; valid stays high across back-to-back words
  task automatic send_vertex(vertex_t v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    offered_q = {offered_q, v};
    in_valid <= 1'b1;
    in_pos_x <= v.px; in_pos_y <= v.py; in_pos_z <= v.pz;
    in_disp_x <= v.dx; in_disp_y <= v.dy; in_disp_z <= v.dz;
    in_stress <= v.st; in_has_stress <= v.hs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain;
    while (tri_words_q.size() != 0 || offered_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic vertex_t row(logic [31:0] px, py, pz, dx, dy, dz,
                                  logic [30:0] st, logic hs);
    vertex_t v;
    v = '{default: '0};
    v.px = px; v.py = py; v.pz = pz; v.dx = dx; v.dy = dy; v.dz = dz;
    v.st = st; v.hs = hs;
    return v;
  endfunction

  function automatic vertex_t typed_row(vertex_t v, logic [31:0] ex, ey, ez,
                                        logic [12:0] er, eg, eb);
    v.typed = 1'b1;
    v.ex = ex; v.ey = ey; v.ez = ez; v.er = er; v.eg = eg; v.eb = eb;
    return v;
  endfunction

  function automatic vertex_t with_norm(vertex_t v, logic [15:0] nx, ny, nz);
    v.tnorm = 1'b1;
    v.enx = nx; v.eny = ny; v.enz = nz;
    return v;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2: return 32'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
      3: return 32'($signed($urandom_range(0, 2 * 67108864)) - 67108864);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_stress();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'(s_low + $urandom_range(0, 3) - 1);
      3: return 31'(s_high + $urandom_range(0, 3) - 1);
      4: return 31'($urandom_range(0, 131072));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    bit quiet_disp;
    quiet_disp = $urandom_range(0, 2) == 0;
    v = row(rand_coord(), rand_coord(), rand_coord(),
            quiet_disp ? 32'd0 : rand_coord(), quiet_disp ? 32'd0 : rand_coord(),
            quiet_disp ? 32'd0 : rand_coord(), rand_stress(), $urandom_range(0, 4) != 0);
    return v;
  endfunction

  task automatic load_regs(logic [31:0] cx, cy, cz, sc, dg, lo, hi);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_CENTER_Z, cz);
    cfg_write(REG_SCALE, sc);
    cfg_write(REG_DEFORM_GAIN, dg);
    cfg_write(REG_STRESS_LOW, lo);
    cfg_write(REG_STRESS_HIGH, hi);
  endtask

  initial begin
    vertex_t dir_rows [$];
    vertex_t v;
    int n_tri;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: unit scale and gain, stress range 0 .. 1.0
    dir_rows = {dir_rows, typed_row(row(0, 0, 0, 0, 0, 0, 0, 1), 0, 0, 0, 0, 0, COLOR_ONE)};
    dir_rows = {dir_rows, typed_row(row(32'h1_0000, 0, 0, 0, 0, 0, 31'h1_0000, 1),
                                    32'h1_0000, 0, 0, COLOR_ONE, 0, 0)};
    dir_rows = {dir_rows, with_norm(typed_row(row(0, 32'h1_0000, 0, 0, 0, 0, 31'h8000, 1),
                                              0, 32'h1_0000, 0, 0, COLOR_ONE, 0),
                                    0, 0, NORM_ONE)};
    // flat triangle without stress: fallback normal, steel-blue
    for (int i = 0; i < 3; i++) begin
      v = typed_row(row(0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 0), 0, 0, 0,
                    STEEL_RED, STEEL_GRN, STEEL_BLU);
      dir_rows = {dir_rows, (i == 2 ? with_norm(v, 0, NORM_ONE, 0) : v)};
    end
    // saturation both ways, stress clamped at both ends
    dir_rows = {dir_rows, typed_row(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        31'h7FFF_FFFF, 1),
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    COLOR_ONE, 0, 0)};
    dir_rows = {dir_rows, typed_row(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1),
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    0, 0, COLOR_ONE)};
    dir_rows = {dir_rows, row(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
                              32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 31'h2AAA_AAAA, 1)};
    dir_rows = {dir_rows, row(32'hFFFF_FFFF, 0, 32'h0001_0000, 0, 32'hFFFF_FFFF, 0,
                              31'h4000, 1)};
    dir_rows = {dir_rows, row(32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000, 0, 0, 0,
                              31'hC000, 1)};
    dir_rows = {dir_rows, row(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF,
                              32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0100, 31'h0001, 1)};
    foreach (dir_rows[i]) send_vertex(dir_rows[i]);
    in_valid <= 1'b0;
    drain();

    // empty stress range gives mid green
    cfg_write(REG_STRESS_LOW, 32'h1_0000);
    for (int i = 0; i < 3; i++)
      send_vertex(typed_row(row(0, 0, 0, 0, 0, 0, 31'(i * 70000), 1), 0, 0, 0,
                            0, COLOR_ONE, 0));
    in_valid <= 1'b0;
    drain();
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_regs(0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h4_0000);
        1: load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        2: load_regs($urandom, $urandom, $urandom, 0, 32'h7FFF_FFFF, 32'h10, 32'h5);
        3: load_regs(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0000_0100, 32'hFFFF_0000,
                     0, 32'h7FFF_FFFF);
        4: load_regs($urandom_range(0, 65535), 0, 32'hFFFF_0000, $urandom_range(1, 262144),
                     $urandom, $urandom_range(0, 65536), $urandom_range(0, 200000));
        default: load_regs(0, 0, 0, 32'h0000_4000, 0, 32'h100, 32'h3_0000);
      endcase
      n_tri = 13;
      for (int t = 0; t < n_tri; t++) begin
        if (ph == 5 && t >= n_tri - 8) calm = 1'b1;
        v = rand_vertex();
        send_vertex(v);
        // degenerate faces: repeat a corner now and then
        if ($urandom_range(0, 7) == 0) begin
          send_vertex(v);
          send_vertex(rand_vertex());
        end else begin
          send_vertex(rand_vertex());
          send_vertex(rand_vertex());
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (300) @(posedge clk);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

[triangle_normal_stress_colorizer_core.f]
sv/tnsc_pkg.sv
sv/tnsc_div.sv
sv/tnsc_sqrt.sv
sv/tnsc_ctrl.sv
sv/tnsc_dp.sv
sv/triangle_normal_stress_colorizer_core.sv
tb/sv/tb_top.sv
